>>> hdl/sfs_pkg.sv
// package for the sprite frame sequencer
// holds sizes, codes, state and memory interface types; no dependencies
`default_nettype none

package sfs_pkg;

  localparam int unsigned MAX_FRAMES = 64;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned IDX_W      = $clog2(MAX_FRAMES);
  localparam int unsigned CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned FUNC_W     = 3;
  localparam int unsigned SEL_W      = 6;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_W      = 7;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ANIM_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK     = 3'd0,
    FN_START    = 3'd1,
    FN_STOP     = 3'd2,
    FN_PAUSE    = 3'd3,
    FN_RESUME   = 3'd4,
    FN_SET_IDX  = 3'd5,
    FN_WR_DUR   = 3'd6,
    FN_NOP      = 3'd7
  } func_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOP = 3'd0,
    MODE_STAY = 3'd1,
    MODE_BACK = 3'd2,
    MODE_GONE = 3'd3,
    MODE_PING = 3'd4
  } mode_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // requests from the sequencer to the frame time memories
  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              el_we;
    logic [IDX_W-1:0]  el_waddr;
    logic [TIME_W-1:0] el_wdata;
    logic              el_clr;
    logic [IDX_W-1:0]  el_caddr;
    logic              du_we;
    logic [IDX_W-1:0]  du_waddr;
    logic [TIME_W-1:0] du_wdata;
  } mem_req_t;

  // registered read data
  typedef struct packed {
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] duration;
  } mem_rsp_t;

endpackage

`default_nettype wire

>>> hdl/sfs_time_mem.sv
// frame time storage: per-frame elapsed time and duration memories
// uses sfs_pkg; elapsed entries carry valid flags so reset reads them as zero
`default_nettype none

module sfs_time_mem
  import sfs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mem_req_t req_i,
  output mem_rsp_t      rsp_o
);

  logic [TIME_W-1:0]     elapsed_mem [MAX_FRAMES];
  logic [TIME_W-1:0]     duration_mem [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] el_valid_q;
  logic [TIME_W-1:0]     el_rd_q;
  logic [TIME_W-1:0]     du_rd_q;
  logic                  el_rd_valid_q;

  // memory arrays, synchronous write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.el_we) begin
      elapsed_mem[req_i.el_waddr] <= req_i.el_wdata;
    end
    if (req_i.du_we) begin
      duration_mem[req_i.du_waddr] <= req_i.du_wdata;
    end
    if (req_i.rd_en) begin
      el_rd_q <= elapsed_mem[req_i.rd_addr];
      du_rd_q <= duration_mem[req_i.rd_addr];
    end
  end

  // valid flags: write sets, clear wins on the same entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      el_valid_q    <= '0;
      el_rd_valid_q <= 1'b0;
    end else begin
      if (req_i.el_we) begin
        el_valid_q[req_i.el_waddr] <= 1'b1;
      end
      if (req_i.el_clr) begin
        el_valid_q[req_i.el_caddr] <= 1'b0;
      end
      if (req_i.rd_en) begin
        el_rd_valid_q <= el_valid_q[req_i.rd_addr];
      end
    end
  end

  // a cleared entry reads as zero
  assign rsp_o.elapsed  = el_rd_valid_q ? el_rd_q : '0;
  assign rsp_o.duration = du_rd_q;

endmodule

`default_nettype wire

>>> hdl/sfs_seq.sv
// sequencer: config registers, item control, frame stepping and result register
// uses sfs_pkg; drives the frame time memories through mem_req_t
`default_nettype none

module sfs_seq
  import sfs_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  wire logic [FUNC_W-1:0]     s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output mem_req_t                   mem_req_o,
  input  wire mem_rsp_t              mem_rsp_i
);

  state_e              state_q, state_d;
  logic [MODE_W-1:0]   mode_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic                down_q, down_d;
  logic                run_q, run_d;
  logic                shown_q, shown_d;
  logic [FUNC_W-1:0]   func_q;
  logic [TIME_W-1:0]   dt_q;
  logic [SEL_W-1:0]    sel_q;
  logic [TIME_W-1:0]   dur_q;
  logic                m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;
  logic                changed;
  logic                accept;
  logic                out_free;
  logic                commit;
  logic [CNT_W-1:0]    used_cnt;
  logic [TIME_W:0]     el_sum;
  logic [TIME_W-1:0]   el_sat;
  logic [CNT_W-1:0]    nxt_idx;
  logic                tick_ok;
  logic                pingpong;

  // handshake and commit control
  assign out_free = !m_valid_q || m_axis_tready;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign used_cnt = (cnt_q > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : cnt_q;
  assign pingpong = (mode_q > MODE_GONE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_EXEC;
      ST_EXEC: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    commit        = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_EXEC: commit = out_free;
      default: ;
    endcase
  end

  // item execution on the data read back from memory
  always_comb begin
    idx_d    = idx_q;
    down_d   = down_q;
    run_d    = run_q;
    shown_d  = shown_q;
    changed  = 1'b0;
    el_sum   = {1'b0, mem_rsp_i.elapsed} + {1'b0, dt_q};
    el_sat   = el_sum[TIME_W] ? '1 : el_sum[TIME_W-1:0];
    nxt_idx  = idx_q + CNT_W'(1);
    tick_ok  = run_q && (idx_q < used_cnt);

    mem_req_o.rd_en    = accept;
    mem_req_o.rd_addr  = idx_q[IDX_W-1:0];
    mem_req_o.el_we    = 1'b0;
    mem_req_o.el_waddr = idx_q[IDX_W-1:0];
    mem_req_o.el_wdata = el_sat;
    mem_req_o.el_clr   = 1'b0;
    mem_req_o.el_caddr = '0;
    mem_req_o.du_we    = 1'b0;
    mem_req_o.du_waddr = sel_q;
    mem_req_o.du_wdata = dur_q;

    case (func_q)
      FN_TICK: begin
        if (tick_ok) begin
          mem_req_o.el_we = commit;
          if (el_sat >= mem_rsp_i.duration) begin
            changed = 1'b1;
            if (!down_q) begin
              idx_d = nxt_idx;
              if (nxt_idx >= used_cnt) begin
                case (mode_q)
                  MODE_LOOP: idx_d = '0;
                  MODE_GONE: begin
                    run_d   = 1'b0;
                    shown_d = 1'b0;
                  end
                  MODE_STAY: begin
                    idx_d = used_cnt - CNT_W'(1);
                    run_d = 1'b0;
                  end
                  MODE_BACK: begin
                    idx_d = '0;
                    run_d = 1'b0;
                  end
                  default: begin
                    down_d = 1'b1;
                    idx_d  = used_cnt - CNT_W'(1);
                  end
                endcase
              end
            end else begin
              if (idx_q == '0) begin
                if (pingpong) down_d = 1'b0;
              end else begin
                idx_d = idx_q - CNT_W'(1);
              end
            end
            // entering a frame while running restarts its time
            if (run_d && (idx_d < used_cnt)) begin
              mem_req_o.el_clr   = commit;
              mem_req_o.el_caddr = idx_d[IDX_W-1:0];
            end
          end
        end
      end
      FN_START: begin
        if (used_cnt != '0) begin
          down_d  = 1'b0;
          run_d   = 1'b1;
          shown_d = 1'b1;
          idx_d   = '0;
          mem_req_o.el_clr   = commit;
          mem_req_o.el_caddr = '0;
        end
      end
      FN_STOP: begin
        run_d   = 1'b0;
        shown_d = 1'b0;
      end
      FN_PAUSE:  run_d = 1'b0;
      FN_RESUME: run_d = 1'b1;
      FN_SET_IDX: begin
        if (CNT_W'(sel_q) < used_cnt) idx_d = CNT_W'(sel_q);
      end
      FN_WR_DUR: mem_req_o.du_we = commit;
      default: ;
    endcase

    m_data_d = OUT_DATA_W'({changed, run_d, shown_d, idx_d});
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mode_q    <= MODE_LOOP;
      cnt_q     <= '0;
      idx_q     <= '0;
      down_q    <= 1'b0;
      run_q     <= 1'b0;
      shown_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ANIM_MODE:   mode_q <= cfg_data_i[MODE_W-1:0];
          REG_FRAME_COUNT: cnt_q  <= cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (commit) begin
        idx_q   <= idx_d;
        down_q  <= down_d;
        run_q   <= run_d;
        shown_q <= shown_d;
      end
      if (commit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // item and result payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= s_axis_tuser;
      dt_q   <= s_axis_tdata[TIME_W-1:0];
      sel_q  <= s_axis_tdata[TIME_W +: SEL_W];
      dur_q  <= s_axis_tdata[TIME_W+SEL_W +: TIME_W];
    end
    if (commit) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

>>> hdl/sprite_frame_sequencer_top.sv
// flow: an accepted item reads the frame time memory, then commits its result and the
//   elapsed write-back; no new item is accepted until it commits, a step set by the
//   read then write-back of the frame time memory; a result held at the output stalls the commit
// reset: control state clears at once, elapsed times read as zero through
//   per-frame valid flags, durations are unknown until written; no clear pass
`default_nettype none

module sprite_frame_sequencer_top
  import sfs_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [IN_DATA_W-1:0] s_axis_tdata,   // dt[31:0], frame_sel[37:32], duration[69:38]
  input  wire logic [FUNC_W-1:0]    s_axis_tuser,   // func[2:0]
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OUT_DATA_W-1:0]     m_axis_tdata    // current_frame[6:0], is_active[7],
                                                    // is_animating[8], frame_changed[9]
);

  mem_req_t mem_req;
  mem_rsp_t mem_rsp;

  sfs_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mem_req_o     (mem_req),
    .mem_rsp_i     (mem_rsp)
  );

  sfs_time_mem u_time_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .rsp_o  (mem_rsp)
  );

`ifndef SYNTH
  // no elapsed write-back while a new item can enter
  a_no_wb_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && mem_req.el_we))
    else $error("elapsed write-back while accepting an item");

  // one item in flight: an accepted item blocks the next
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second item accepted while one is in flight");

  // the frame index never passes the frame limit
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[CNT_W-1:0] <= CNT_W'(MAX_FRAMES)))
    else $error("frame index beyond frame limit");
`endif

endmodule

`default_nettype wire

>>> bench/sprite_frame_sequencer_top_tb.sv
`timescale 1ns / 1ps
// self-checking bench for sprite_frame_sequencer_top: directed table, then random phases
// predicts the frame state after every command item; depends on sfs_pkg and the rtl

module sprite_frame_sequencer_top_tb;
  import sfs_pkg::*;

  localparam logic [TIME_W-1:0] T_MAX      = '1;
  localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;  // unused code, behaves as ping-pong
  localparam bit ROW_ITEM     = 1'b0;
  localparam bit ROW_CFG      = 1'b1;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 125;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [CNT_W-1:0] current_frame;
    logic             is_active;
    logic             is_animating;
    logic             frame_changed;
  } frame_state_t;

  typedef struct packed {
    bit                row_kind;
    logic [MODE_W-1:0] mode;
    logic [CNT_W-1:0]  count;
    func_e             fn;
    logic [TIME_W-1:0] dt;
    logic [SEL_W-1:0]  sel;
    logic [TIME_W-1:0] dur;
    bit                typed;
    frame_state_t      res;
  } dir_row_t;

  localparam int N_DIR = 32;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // after reset with no frames: ticks and start do nothing, resume still runs
    '{ROW_ITEM, MODE_LOOP, 7'd0, FN_TICK,   32'd0, 6'd0,  32'd0, 1'b1, '{7'd0, 1'b0, 1'b0, 1'b0}},
    '{ROW_ITEM, MODE_LOOP, 7'd0, FN_START,  32'd0, 6'd0,  32'd0, 1'b1, '{7'd0, 1'b0, 1'b0, 1'b0}},
    '{ROW_ITEM, MODE_LOOP, 7'd0, FN_RESUME, 32'd0, 6'd0,  32'd0, 1'b1, '{7'd0, 1'b0, 1'b1, 1'b0}},
    '{ROW_ITEM, MODE_LOOP, 7'd0, FN_TICK,   T_MAX, 6'd0,  32'd0, 1'b1, '{7'd0, 1'b0, 1'b1, 1'b0}},
    // durations, top slot included
    '{ROW_ITEM, MODE_LOOP, 7'd0, FN_WR_DUR, 32'd0, 6'd63, T_MAX, 1'b1, '{7'd0, 1'b0, 1'b1, 1'b0}},
    '{ROW_ITEM, MODE_LOOP, 7'd0, FN_WR_DUR, 32'd0, 6'd0,  T_MAX, 1'b0, '0},
    '{ROW_ITEM, MODE_LOOP, 7'd0, FN_WR_DUR, 32'd0, 6'd1,  32'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_LOOP, 7'd0, FN_WR_DUR, 32'd0, 6'd2,  32'd5, 1'b0, '0},
    // loop over three frames, elapsed time saturating on the first
    '{ROW_CFG,  MODE_LOOP, 7'd3, FN_NOP,    32'd0, 6'd0,  32'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_LOOP, 7'd3, FN_START,  32'd0, 6'd0,  32'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_LOOP, 7'd3, FN_TICK,   32'h7FFF_FFFF, 6'd0, 32'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_LOOP, 7'd3, FN_TICK,   T_MAX, 6'd0,  32'd0, 1'b1, '{7'd1, 1'b1, 1'b1, 1'b1}},
    '{ROW_ITEM, MODE_LOOP, 7'd3, FN_TICK,   32'd0, 6'd0,  32'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_LOOP, 7'd3, FN_TICK,   32'd5, 6'd0,  32'd0, 1'b0, '0},
    // set index past the count is ignored
    '{ROW_ITEM, MODE_LOOP, 7'd3, FN_SET_IDX, 32'd0, 6'd63, 32'd0, 1'b1, '{7'd0, 1'b1, 1'b1, 1'b0}},
    // ping-pong: the end frame repeats, then the index walks back
    '{ROW_CFG,  MODE_PING, 7'd3, FN_NOP,    32'd0, 6'd0,  32'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_PING, 7'd3, FN_START,  32'd0, 6'd0,  32'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_PING, 7'd3, FN_TICK,   T_MAX, 6'd0,  32'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_PING, 7'd3, FN_TICK,   32'd0, 6'd0,  32'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_PING, 7'd3, FN_TICK,   32'd5, 6'd0,  32'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_PING, 7'd3, FN_TICK,   32'd5, 6'd0,  32'd0, 1'b0, '0},
    // leave ping-pong while stepping down: the index sticks at frame zero
    '{ROW_CFG,  MODE_LOOP, 7'd3, FN_NOP,    32'd0, 6'd0,  32'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_LOOP, 7'd3, FN_TICK,   32'd0, 6'd0,  32'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_LOOP, 7'd3, FN_WR_DUR, 32'd0, 6'd0,  32'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_LOOP, 7'd3, FN_TICK,   32'd0, 6'd0,  32'd0, 1'b0, '0},
    // unused mode code with a single frame: frame zero repeats both ways
    '{ROW_CFG,  MODE_SPARE, 7'd1, FN_NOP,   32'd0, 6'd0,  32'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_SPARE, 7'd1, FN_START, 32'd0, 6'd0,  32'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_SPARE, 7'd1, FN_TICK,  32'd0, 6'd0,  32'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_SPARE, 7'd1, FN_TICK,  32'd0, 6'd0,  32'd0, 1'b0, '0},
    // once and gone: index lands on the count, nothing shown
    '{ROW_CFG,  MODE_GONE, 7'd1, FN_NOP,    32'd0, 6'd0,  32'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_GONE, 7'd1, FN_START,  32'd0, 6'd0,  32'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_GONE, 7'd1, FN_TICK,   32'd0, 6'd0,  32'd0, 1'b1, '{7'd1, 1'b0, 1'b0, 1'b1}}
  };

  localparam logic [MODE_W-1:0] PHASE_MODES [10] = '{
    MODE_LOOP, MODE_STAY, MODE_BACK, MODE_GONE, MODE_PING,
    MODE_PING, MODE_LOOP, MODE_BACK, MODE_STAY, MODE_GONE
  };
  localparam logic [CNT_W-1:0] PHASE_COUNTS [10] = '{
    7'd4, 7'd64, 7'd1, 7'd6, 7'd1, 7'd64, 7'd0, 7'd5, 7'd2, 7'd3
  };

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = REG_ANIM_MODE;
  logic [CFG_W-1:0]      cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // dt, frame_sel, duration
  logic [FUNC_W-1:0]     s_axis_tuser  = FN_NOP;  // func
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;  // current_frame, is_active, is_animating, frame_changed

  // predicted sequencer state
  logic [MODE_W-1:0] seq_mode;
  logic [CNT_W-1:0]  seq_count;
  logic [CNT_W-1:0]  seq_idx;
  bit                seq_down;
  bit                seq_run;
  bit                seq_shown;
  logic [TIME_W-1:0] seq_dur     [MAX_FRAMES];
  bit                seq_dur_set [MAX_FRAMES];
  logic [TIME_W-1:0] seq_elapsed [MAX_FRAMES];

  frame_state_t pending_frames [$];
  int mismatches    = 0;
  int send_gap_pct  = 0;
  int ready_gap_pct = 0;
  int hold_reqs     = 0;

  sprite_frame_sequencer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [CNT_W-1:0] frames_in_use();
    return (seq_count > MAX_FRAMES) ? CNT_W'(MAX_FRAMES) : seq_count;
  endfunction

  // add time to the current frame; returns 1 when the frame ended
  function automatic bit tick_frame(logic [TIME_W-1:0] dt);
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  nxt;
    logic [SEL_W-1:0]  slot;
    logic [TIME_W:0]   sum;
    cnt = frames_in_use();
    if (!seq_run || seq_idx >= cnt) return 1'b0;
    slot = seq_idx[SEL_W-1:0];
    sum = {1'b0, seq_elapsed[slot]} + {1'b0, dt};
    seq_elapsed[slot] = sum[TIME_W] ? T_MAX : sum[TIME_W-1:0];
    if (seq_elapsed[slot] < seq_dur[slot]) return 1'b0;
    nxt = seq_idx;
    if (!seq_down) begin
      nxt = nxt + CNT_W'(1);
      if (nxt >= cnt) begin
        case (seq_mode)
          MODE_LOOP: nxt = '0;
          MODE_GONE: begin
            seq_run   = 1'b0;
            seq_shown = 1'b0;
          end
          MODE_STAY: begin
            nxt     = cnt - CNT_W'(1);
            seq_run = 1'b0;
          end
          MODE_BACK: begin
            nxt     = '0;
            seq_run = 1'b0;
          end
          default: begin
            seq_down = 1'b1;
            nxt      = cnt - CNT_W'(1);
          end
        endcase
      end
    end else if (nxt == '0) begin
      // bottom end: only ping-pong turns around, other modes stick at zero
      if (seq_mode > MODE_GONE) seq_down = 1'b0;
    end else begin
      nxt = nxt - CNT_W'(1);
    end
    seq_idx = nxt;
    if (seq_run && nxt < cnt) seq_elapsed[nxt[SEL_W-1:0]] = '0;
    return 1'b1;
  endfunction

  // frame state after one command item
  function automatic frame_state_t predict_frame_state(func_e fn, logic [TIME_W-1:0] dt,
      logic [SEL_W-1:0] sel, logic [TIME_W-1:0] dur);
    frame_state_t st;
    bit ended;
    logic [CNT_W-1:0] cnt;
    ended = 1'b0;
    cnt = frames_in_use();
    case (fn)
      FN_TICK: ended = tick_frame(dt);
      FN_START: begin
        if (cnt != '0) begin
          seq_down       = 1'b0;
          seq_run        = 1'b1;
          seq_shown      = 1'b1;
          seq_idx        = '0;
          seq_elapsed[0] = '0;
        end
      end
      FN_STOP: begin
        seq_run   = 1'b0;
        seq_shown = 1'b0;
      end
      FN_PAUSE:  seq_run = 1'b0;
      FN_RESUME: seq_run = 1'b1;
      FN_SET_IDX: begin
        if (CNT_W'(sel) < cnt) seq_idx = CNT_W'(sel);
      end
      FN_WR_DUR: begin
        seq_dur[sel]     = dur;
        seq_dur_set[sel] = 1'b1;
      end
      default: ;
    endcase
    st.current_frame = seq_idx;
    st.is_active     = seq_shown;
    st.is_animating  = seq_run;
    st.frame_changed = ended;
    return st;
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return $urandom_range(12);
    if (pick < 90) return $urandom_range(1000);
    if (pick < 97) return $urandom();
    return T_MAX;
  endfunction

  // offer one item, hold it until taken, then log what should come back
  task automatic send_item(func_e fn, logic [TIME_W-1:0] dt, logic [SEL_W-1:0] sel,
      logic [TIME_W-1:0] dur, bit typed, frame_state_t res);
    frame_state_t want;
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {2'b00, dur, sel, dt};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    want = predict_frame_state(fn, dt, sel, dur);
    if (typed) want = res;
    pending_frames = {pending_frames, want};
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [MODE_W-1:0] mode, logic [CNT_W-1:0] count);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_ANIM_MODE;
    cfg_data_i <= CFG_W'(mode);
    @(posedge clk_i);
    seq_mode = mode;
    cfg_idx_i  <= REG_FRAME_COUNT;
    cfg_data_i <= count;
    @(posedge clk_i);
    seq_count = count;
    cfg_we_i <= 1'b0;
  endtask

  // mostly ticks with short times so frames turn over, plus the other commands
  task automatic send_random_item();
    func_e             fn;
    logic [TIME_W-1:0] dt;
    logic [TIME_W-1:0] dur;
    logic [SEL_W-1:0]  sel;
    logic [CNT_W-1:0]  cnt;
    int                pick;
    cnt  = frames_in_use();
    pick = $urandom_range(99);
    if (pick < 55) fn = FN_TICK;
    else if (pick < 63) fn = FN_START;
    else if (pick < 66) fn = FN_STOP;
    else if (pick < 70) fn = FN_PAUSE;
    else if (pick < 75) fn = FN_RESUME;
    else if (pick < 83) fn = FN_SET_IDX;
    else if (pick < 98) fn = FN_WR_DUR;
    else fn = FN_NOP;
    if (!seq_run && $urandom_range(3) == 0) fn = FN_START;
    dt  = rand_time();
    dur = rand_time();
    sel = SEL_W'($urandom_range(MAX_FRAMES - 1));
    if ((fn == FN_SET_IDX || fn == FN_WR_DUR) && cnt != '0 && $urandom_range(9) < 7)
      sel = SEL_W'($urandom_range(cnt - 1));
    // a tick must never read a duration that was never written
    if (fn == FN_TICK && seq_run && seq_idx < cnt && !seq_dur_set[seq_idx[SEL_W-1:0]]) begin
      fn  = FN_WR_DUR;
      sel = seq_idx[SEL_W-1:0];
    end
    send_item(fn, dt, sel, dur, 1'b0, '0);
  endtask

  // result side ready, with one long hold-off on request
  initial begin : ready_side
    int seen;
    seen = 0;
    forever begin
      @(posedge clk_i);
      if (seen != hold_reqs) begin
        seen = hold_reqs;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= ready_gap_pct);
    end
  end

  function automatic void check_field(string name, logic [CNT_W-1:0] want,
      logic [CNT_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // compare each result item with the oldest prediction
  initial begin : result_check
    frame_state_t want;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_frames.size() == 0) begin
          mismatches++;
          $display("%0t: expected no result, got %h", $time, m_axis_tdata);
        end else begin
          want = pending_frames.pop_front();
          check_field("current_frame", want.current_frame, m_axis_tdata[6:0]);
          check_field("is_active", CNT_W'(want.is_active), CNT_W'(m_axis_tdata[7]));
          check_field("is_animating", CNT_W'(want.is_animating), CNT_W'(m_axis_tdata[8]));
          check_field("frame_changed", CNT_W'(want.frame_changed), CNT_W'(m_axis_tdata[9]));
        end
      end
    end
  end

  initial begin : stimulus
    logic [MODE_W-1:0] mode;
    logic [CNT_W-1:0]  count;
    seq_mode  = MODE_LOOP;
    seq_count = '0;
    seq_idx   = '0;
    seq_down  = 1'b0;
    seq_run   = 1'b0;
    seq_shown = 1'b0;
    for (int f = 0; f < MAX_FRAMES; f++) begin
      seq_dur[f]     = '0;
      seq_dur_set[f] = 1'b0;
      seq_elapsed[f] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int r = 0; r < N_DIR; r++) begin
      if (DIR_ROWS[r].row_kind == ROW_CFG) begin
        wait_drained();
        program_regs(DIR_ROWS[r].mode, DIR_ROWS[r].count);
      end else begin
        send_item(DIR_ROWS[r].fn, DIR_ROWS[r].dt, DIR_ROWS[r].sel, DIR_ROWS[r].dur,
                  DIR_ROWS[r].typed, DIR_ROWS[r].res);
      end
    end

    // random phases, each with its own settings and idling pattern
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      if (ph < 10) begin
        mode  = PHASE_MODES[ph];
        count = PHASE_COUNTS[ph];
      end else begin
        mode  = MODE_W'($urandom_range(MODE_SPARE));
        count = CNT_W'($urandom_range(MAX_FRAMES));
      end
      program_regs(mode, count);
      case (ph % 4)
        0: begin
          send_gap_pct  = 0;
          ready_gap_pct = 0;
        end
        1: begin
          send_gap_pct  = 51;
          ready_gap_pct = 0;
        end
        2: begin
          send_gap_pct  = 0;
          ready_gap_pct = 51;
        end
        default: begin
          send_gap_pct  = 10;
          ready_gap_pct = 10;
        end
      endcase
      // back-pressure long enough to fill the block while items keep coming
      if (ph == 4) hold_reqs++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph % 4 == 1 && n == PHASE_ITEMS / 2) wait_drained();
        send_random_item();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/sfs_pkg.sv
hdl/sfs_time_mem.sv
hdl/sfs_seq.sv
hdl/sprite_frame_sequencer_top.sv
bench/sprite_frame_sequencer_top_tb.sv
